// File: rtl/bll_pkg.sv
// shared constants and control types for the binary lifting ancestor core
`default_nettype none

package bll_pkg;

  localparam int NODE_W     = 10;
  localparam int ENTRY_W    = NODE_W + 1;
  localparam int MAX_NODES  = 1 << NODE_W;
  localparam int LEVELS_DEF = 10;
  localparam int CNT_W      = 11;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [ENTRY_W-1:0] ABSENT = ENTRY_W'(1) << NODE_W;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic load_wr;
    logic q_start;
    logic q_order;
    logic lift_rd;
    logic lift_skip;
    logic lift_take;
    logic res_same;
    logic desc_init;
    logic desc_rd;
    logic desc_take;
    logic fin_rd;
    logic fin_take;
    logic build_init;
    logic build_rd1;
    logic build_rd2;
    logic build_wr;
    logic out_push;
  } bll_cmd_t;

  typedef struct packed {
    logic build_empty;
    logic build_last_node;
    logic build_last_lvl;
    logic lift_done;
    logic diff_bit;
    logic same;
    logic lvl_zero;
    logic out_free;
  } bll_sts_t;

endpackage

`default_nettype wire

// File: rtl/binary_lifting_lca_core.sv
// top level of the binary lifting lowest common ancestor core
// load transfer: one table and depth write; build: fills table levels 1 to LEVELS-1
// for min(node_count,MAX_NODES) nodes; query: result register set by the
// lift and descend loops, each step a read of the single jump table memory
// one item in work at a time; a waiting result does not block the next transfer
// reset clears control, the result valid flag and node_count to 1; memories keep contents
`default_nettype none

module binary_lifting_lca_core #(
  parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bll_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bll_pkg::DATA_W-1:0]  pwdata,
  output logic [bll_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  kind,
  input  wire logic [bll_pkg::NODE_W-1:0]  entry_node,
  input  wire logic [bll_pkg::NODE_W-1:0]  entry_depth,
  input  wire logic [bll_pkg::NODE_W-1:0]  entry_parent,
  input  wire logic                        entry_has_parent,
  input  wire logic [bll_pkg::NODE_W-1:0]  query_first,
  input  wire logic [bll_pkg::NODE_W-1:0]  query_second,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bll_pkg::NODE_W-1:0]       common_ancestor
);

  logic [bll_pkg::CNT_W-1:0] node_count;
  logic                      reg_sel;
  bll_pkg::bll_cmd_t         cmd;
  bll_pkg::bll_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == bll_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= bll_pkg::CNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      node_count <= pwdata[bll_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? bll_pkg::DATA_W'(node_count) : '0;

  bll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  bll_datapath #(
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .node_count       (node_count),
    .entry_node       (entry_node),
    .entry_depth      (entry_depth),
    .entry_parent     (entry_parent),
    .entry_has_parent (entry_has_parent),
    .query_first      (query_first),
    .query_second     (query_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .common_ancestor  (common_ancestor)
  );

endmodule

`default_nettype wire

// File: rtl/bll_ctrl.sv
// control state machine for load, table build and ancestor query
`default_nettype none

module bll_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        kind,
  input  wire bll_pkg::bll_sts_t sts,
  output bll_pkg::bll_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_Q_ORD  = 4'd1;
  localparam logic [3:0] S_LIFT   = 4'd2;
  localparam logic [3:0] S_L_WAIT = 4'd3;
  localparam logic [3:0] S_D_RD   = 4'd4;
  localparam logic [3:0] S_D_WAIT = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_WAIT = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_B_INIT = 4'd9;
  localparam logic [3:0] S_B_RD1  = 4'd10;
  localparam logic [3:0] S_B_RD2  = 4'd11;
  localparam logic [3:0] S_B_WR   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            bll_pkg::KIND_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            bll_pkg::KIND_BUILD: begin
              state_next = S_B_INIT;
            end
            bll_pkg::KIND_QUERY: begin
              cmd.q_start = 1'b1;
              state_next  = S_Q_ORD;
            end
            default: begin
            end
          endcase
        end
      end
      S_Q_ORD: begin
        cmd.q_order = 1'b1;
        state_next  = S_LIFT;
      end
      S_LIFT: begin
        if (sts.lift_done) begin
          if (sts.same) begin
            cmd.res_same = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.desc_init = 1'b1;
            state_next    = S_D_RD;
          end
        end else if (sts.diff_bit) begin
          cmd.lift_rd = 1'b1;
          state_next  = S_L_WAIT;
        end else begin
          cmd.lift_skip = 1'b1;
        end
      end
      S_L_WAIT: begin
        cmd.lift_take = 1'b1;
        state_next    = S_LIFT;
      end
      S_D_RD: begin
        cmd.desc_rd = 1'b1;
        state_next  = S_D_WAIT;
      end
      S_D_WAIT: begin
        cmd.desc_take = 1'b1;
        state_next    = sts.lvl_zero ? S_F_RD : S_D_RD;
      end
      S_F_RD: begin
        cmd.fin_rd = 1'b1;
        state_next = S_F_WAIT;
      end
      S_F_WAIT: begin
        cmd.fin_take = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_push = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_B_INIT: begin
        cmd.build_init = 1'b1;
        state_next     = sts.build_empty ? S_IDLE : S_B_RD1;
      end
      S_B_RD1: begin
        cmd.build_rd1 = 1'b1;
        state_next    = S_B_RD2;
      end
      S_B_RD2: begin
        cmd.build_rd2 = 1'b1;
        state_next    = S_B_WR;
      end
      S_B_WR: begin
        cmd.build_wr = 1'b1;
        state_next   = (sts.build_last_node && sts.build_last_lvl) ? S_IDLE : S_B_RD1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bll_datapath.sv
// jump table and depth memories, query registers and result register
`default_nettype none

module bll_datapath #(
  parameter int LEVELS = bll_pkg::LEVELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bll_pkg::bll_cmd_t          cmd,
  output bll_pkg::bll_sts_t               sts,
  input  wire logic [bll_pkg::CNT_W-1:0]  node_count,
  input  wire logic [bll_pkg::NODE_W-1:0] entry_node,
  input  wire logic [bll_pkg::NODE_W-1:0] entry_depth,
  input  wire logic [bll_pkg::NODE_W-1:0] entry_parent,
  input  wire logic                       entry_has_parent,
  input  wire logic [bll_pkg::NODE_W-1:0] query_first,
  input  wire logic [bll_pkg::NODE_W-1:0] query_second,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [bll_pkg::NODE_W-1:0]      common_ancestor
);

  localparam int NODE_W    = bll_pkg::NODE_W;
  localparam int ENTRY_W   = bll_pkg::ENTRY_W;
  localparam int CNT_W     = bll_pkg::CNT_W;
  localparam int TBL_DEPTH = bll_pkg::MAX_NODES * LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int LCNT_W    = $clog2(LEVELS + 1);

  logic [ENTRY_W-1:0] tbl [TBL_DEPTH];
  logic [NODE_W-1:0]  dep [bll_pkg::MAX_NODES];

  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;
  logic [NODE_W-1:0]  dep_a;
  logic [NODE_W-1:0]  dep_b;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;
  logic [NODE_W-1:0]  diff;
  logic [LCNT_W-1:0]  lvl;
  logic [NODE_W-1:0]  idx;
  logic [NODE_W-1:0]  res;
  logic [CNT_W-1:0]   count;

  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_wa;
  logic [ENTRY_W-1:0] tbl_wd;
  logic               rd_en_a;
  logic               rd_en_b;
  logic [TBL_AW-1:0]  ra_a;
  logic [TBL_AW-1:0]  ra_b;

  function automatic logic [TBL_AW-1:0] taddr(input logic [NODE_W-1:0] n,
                                              input logic [LCNT_W-1:0] l);
    return TBL_AW'(n) * TBL_AW'(LEVELS) + TBL_AW'(l);
  endfunction

  assign count = (node_count > CNT_W'(bll_pkg::MAX_NODES)) ?
                 CNT_W'(bll_pkg::MAX_NODES) : node_count;

  // table port selection
  always_comb begin
    rd_en_a = cmd.lift_rd || cmd.desc_rd || cmd.fin_rd || cmd.build_rd1;
    rd_en_b = cmd.desc_rd || cmd.build_rd2;
    ra_a    = taddr(idx, lvl);
    if (cmd.lift_rd) begin
      ra_a = taddr(node_b, lvl);
    end else if (cmd.desc_rd) begin
      ra_a = taddr(node_a, lvl);
    end else if (cmd.fin_rd) begin
      ra_a = taddr(node_a, '0);
    end
    ra_b = cmd.build_rd2 ? taddr(rd_a[NODE_W-1:0], lvl) : taddr(node_b, lvl);
    tbl_we = cmd.load_wr || cmd.build_wr;
    if (cmd.load_wr) begin
      tbl_wa = taddr(entry_node, '0);
      tbl_wd = entry_has_parent ? {1'b0, entry_parent} : bll_pkg::ABSENT;
    end else begin
      tbl_wa = taddr(idx, LCNT_W'(lvl + 1'b1));
      tbl_wd = rd_a[NODE_W] ? bll_pkg::ABSENT : rd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    if (rd_en_a) begin
      rd_a <= tbl[ra_a];
    end
    if (rd_en_b) begin
      rd_b <= tbl[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      dep[entry_node] <= entry_depth;
    end
    if (cmd.q_start) begin
      dep_a <= dep[query_first];
      dep_b <= dep[query_second];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      node_a <= query_first;
      node_b <= query_second;
    end
    if (cmd.q_order) begin
      lvl <= '0;
      if (dep_a > dep_b) begin
        node_a <= node_b;
        node_b <= node_a;
        diff   <= dep_a - dep_b;
      end else begin
        diff <= dep_b - dep_a;
      end
    end
    if (cmd.lift_skip) begin
      diff <= diff >> 1;
      lvl  <= LCNT_W'(lvl + 1'b1);
    end
    if (cmd.lift_take) begin
      if (!rd_a[NODE_W]) begin
        node_b <= rd_a[NODE_W-1:0];
      end
      diff <= diff >> 1;
      lvl  <= LCNT_W'(lvl + 1'b1);
    end
    if (cmd.res_same) begin
      res <= node_a;
    end
    if (cmd.desc_init) begin
      lvl <= LCNT_W'(LEVELS - 1);
    end
    if (cmd.desc_take) begin
      if (!rd_a[NODE_W] && (rd_a != rd_b)) begin
        node_a <= rd_a[NODE_W-1:0];
        if (!rd_b[NODE_W]) begin
          node_b <= rd_b[NODE_W-1:0];
        end
      end
      if (lvl != '0) begin
        lvl <= LCNT_W'(lvl - 1'b1);
      end
    end
    if (cmd.fin_take) begin
      res <= rd_a[NODE_W] ? node_a : rd_a[NODE_W-1:0];
    end
    if (cmd.build_init) begin
      idx <= '0;
      lvl <= '0;
    end
    if (cmd.build_wr) begin
      if (sts.build_last_node) begin
        idx <= '0;
        lvl <= LCNT_W'(lvl + 1'b1);
      end else begin
        idx <= NODE_W'(idx + 1'b1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      common_ancestor <= res;
    end
  end

  always_comb begin
    sts.build_empty     = (count == '0) || (LEVELS < 2);
    sts.build_last_node = ({1'b0, idx} == CNT_W'(count - 1'b1));
    sts.build_last_lvl  = (lvl == LCNT_W'(LEVELS - 2));
    sts.lift_done       = (diff == '0) || (lvl == LCNT_W'(LEVELS));
    sts.diff_bit        = diff[0];
    sts.same            = (node_a == node_b);
    sts.lvl_zero        = (lvl == '0);
    sts.out_free        = !out_valid || out_ready;
  end

endmodule

`default_nettype wire
